[rtl/qti_pkg.sv]
// ----------------------------------------------------------------------------
// qti_pkg: shared types and constants for the quintic trajectory interpolator
// Multiplier request and response, status codes, register indexes and the
// solver micro-program.
// ----------------------------------------------------------------------------
package qti_pkg;

	// rounding shift applied by the multiply unit
	typedef enum logic [1:0] {SH_0, SH_16, SH_32, SH_33} sh_sel_t;

	typedef struct packed {
		logic    start;
		sh_sel_t sh;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mul_rsp_t;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_START_POS  = 3'd0;
	localparam logic [2:0] CFG_START_VEL  = 3'd1;
	localparam logic [2:0] CFG_START_ACC  = 3'd2;
	localparam logic [2:0] CFG_END_POS    = 3'd3;
	localparam logic [2:0] CFG_END_VEL    = 3'd4;
	localparam logic [2:0] CFG_END_ACC    = 3'd5;
	localparam logic [2:0] CFG_START_TIME = 3'd6;
	localparam logic [2:0] CFG_END_TIME   = 3'd7;

	localparam int TIME_W   = 24;
	localparam int DIV_BITS = TIME_W + 33;	// quotient bits of (|tau|<<32 + den/2) / den

	// solver micro-program
	typedef enum logic [3:0] {
		A_T, A_SV, A_EV, A_SA, A_SP, A_H, A_X3, A_X4, A_X5, A_V0, A_V1
	} a_sel_t;
	typedef enum logic [1:0] {B_T, B_T2, B_K} b_sel_t;
	typedef enum logic [1:0] {M_SET, M_ADD, M_SUB} acc_mode_t;
	typedef enum logic [3:0] {
		D_NONE, D_T2, D_V1, D_C0, D_C1, D_C2, D_C3, D_C4, D_C5
	} dst_t;

	typedef struct packed {
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		logic signed [31:0] konst;
		sh_sel_t           sh;
		acc_mode_t         mode;
		dst_t              dst;
	} uop_t;

	localparam int NUM_UOPS = 17;

	function automatic uop_t solve_uop(input logic [4:0] pc);
		uop_t u;
		u = '{A_T, B_T, 32'sd0, SH_0, M_SET, D_NONE};
		case (pc)
			5'd0:  u = '{A_T,  B_T,  32'sd0,     SH_0,  M_SET, D_T2};
			5'd1:  u = '{A_SV, B_T,  32'sd0,     SH_0,  M_SET, D_C1};
			5'd2:  u = '{A_EV, B_T,  32'sd0,     SH_0,  M_SET, D_V1};
			5'd3:  u = '{A_SP, B_K,  32'sd65536, SH_0,  M_SET, D_C0};
			5'd4:  u = '{A_SA, B_T2, 32'sd0,     SH_33, M_SET, D_C2};
			5'd5:  u = '{A_H,  B_K,  32'sd10,    SH_0,  M_SET, D_NONE};
			5'd6:  u = '{A_V1, B_K,  -32'sd4,    SH_0,  M_ADD, D_NONE};
			5'd7:  u = '{A_V0, B_K,  -32'sd6,    SH_0,  M_ADD, D_NONE};
			5'd8:  u = '{A_X3, B_T2, 32'sd0,     SH_33, M_SUB, D_C3};
			5'd9:  u = '{A_H,  B_K,  -32'sd15,   SH_0,  M_SET, D_NONE};
			5'd10: u = '{A_V1, B_K,  32'sd7,     SH_0,  M_ADD, D_NONE};
			5'd11: u = '{A_V0, B_K,  32'sd8,     SH_0,  M_ADD, D_NONE};
			5'd12: u = '{A_X4, B_T2, 32'sd0,     SH_33, M_ADD, D_C4};
			5'd13: u = '{A_H,  B_K,  32'sd6,     SH_0,  M_SET, D_NONE};
			5'd14: u = '{A_V0, B_K,  -32'sd3,    SH_0,  M_ADD, D_NONE};
			5'd15: u = '{A_V1, B_K,  -32'sd3,    SH_0,  M_ADD, D_NONE};
			5'd16: u = '{A_X5, B_T2, 32'sd0,     SH_33, M_ADD, D_C5};
			default: u = '{A_T, B_T, 32'sd0, SH_0, M_SET, D_NONE};
		endcase
		return u;
	endfunction

endpackage

[rtl/quintic_trajectory_interpolator.sv]
// Each request runs the divider, then six passes through the shared
//   multiplier; the first request after a register write first runs the
//   17-step coefficient solve.
// One request at a time; a zero-length interval skips the solve and divide.
// Reset: asynchronous, clears control state, registers go to their defaults
//   and the coefficients are marked stale.
// ----------------------------------------------------------------------------
// quintic_trajectory_interpolator: quintic polynomial position interpolator
// Solves the normalised coefficients from the boundary registers, then
// evaluates position by Horner's rule on one shared multiply unit.
// ----------------------------------------------------------------------------
module quintic_trajectory_interpolator import qti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        sample_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position,
	output logic [1:0]         status
);

	typedef enum logic [3:0] {
		S_IDLE, S_SOLVE_ISSUE, S_SOLVE_WAIT, S_DIV_ISSUE, S_DIV,
		S_HORN_ISSUE, S_HORN_WAIT, S_FIN_ISSUE, S_FIN_WAIT, S_OUT
	} state_t;

	// configuration registers
	logic signed [31:0] sp_q, sv_q, sa_q, ep_q, ev_q, ea_q;
	logic [23:0]        t0_q, t1_q;

	state_t             state_q;
	logic [4:0]         pc_q;
	logic [2:0]         k_q;
	logic               cvalid_q, ovf_q;
	logic signed [24:0] t_q, tau_q;
	logic signed [63:0] c_q [6];
	logic signed [63:0] t2_q, v1_q, sacc_q, acc_q, u_q;
	logic signed [31:0] pos_q;
	logic [1:0]         stat_q;
	logic               out_valid_q;
	logic signed [31:0] position_q;
	logic [1:0]         status_q;

	uop_t               uop;
	mul_req_t           mreq;
	mul_rsp_t           mrsp;
	logic signed [63:0] mul_a, mul_b, mres;
	logic signed [63:0] h, x3, x4, x5, sacc_n, hsum, hsat;
	logic               hovf;
	logic signed [24:0] t_n, tau_n;
	logic               div_start, div_done;
	logic [DIV_BITS-1:0] quot;

	// hold the boundary registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0; sv_q <= '0; sa_q <= '0;
			ep_q <= '0; ev_q <= '0; ea_q <= '0;
			t0_q <= '0; t1_q <= 24'd655360;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_START_POS:  sp_q <= cfg_data;
				CFG_START_VEL:  sv_q <= cfg_data;
				CFG_START_ACC:  sa_q <= cfg_data;
				CFG_END_POS:    ep_q <= cfg_data;
				CFG_END_VEL:    ev_q <= cfg_data;
				CFG_END_ACC:    ea_q <= cfg_data;
				CFG_START_TIME: t0_q <= cfg_data[23:0];
				CFG_END_TIME:   t1_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// interval and local time of the incoming request
	assign t_n   = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
	assign tau_n = $signed({1'b0, sample_time}) - $signed({1'b0, t0_q});

	// solver operands
	assign h  = 64'(ep_q - 33'(sp_q)) <<< 16;
	assign x3 = 64'(sa_q) + (64'(sa_q) <<< 1) - 64'(ea_q);
	assign x4 = 64'(sa_q) + (64'(sa_q) <<< 1) - (64'(ea_q) <<< 1);
	assign x5 = 64'(ea_q) - 64'(sa_q);

	assign uop = solve_uop(pc_q);

	// drive the shared multiplier
	always_comb begin
		mreq.start = 1'b0;
		mreq.sh    = uop.sh;
		mul_a      = acc_q;
		mul_b      = u_q;
		case (state_q)
			S_SOLVE_ISSUE: begin
				mreq.start = 1'b1;
				case (uop.a_sel)
					A_T:     mul_a = 64'(t_q);
					A_SV:    mul_a = 64'(sv_q);
					A_EV:    mul_a = 64'(ev_q);
					A_SA:    mul_a = 64'(sa_q);
					A_SP:    mul_a = 64'(sp_q);
					A_H:     mul_a = h;
					A_X3:    mul_a = x3;
					A_X4:    mul_a = x4;
					A_X5:    mul_a = x5;
					A_V0:    mul_a = c_q[1];
					A_V1:    mul_a = v1_q;
					default: mul_a = '0;
				endcase
				case (uop.b_sel)
					B_T:     mul_b = 64'(t_q);
					B_T2:    mul_b = t2_q;
					B_K:     mul_b = 64'(uop.konst);
					default: mul_b = '0;
				endcase
			end
			S_HORN_ISSUE: begin
				mreq.start = 1'b1;
				mreq.sh    = SH_32;
			end
			S_FIN_ISSUE: begin
				mreq.start = 1'b1;
				mreq.sh    = SH_16;
				mul_b      = 64'sd1;
			end
			default: ;
		endcase
	end

	qti_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (mul_a),
		.b      (mul_b),
		.rsp    (mrsp),
		.res    (mres)
	);

	assign div_start = (state_q == S_DIV_ISSUE);

	qti_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (tau_q[24] ? 24'(-tau_q) : tau_q[23:0]),
		.den     (t_q[24] ? 24'(-t_q) : t_q[23:0]),
		.done    (div_done),
		.quot    (quot)
	);

	// accumulate a solver term
	always_comb begin
		case (uop.mode)
			M_ADD:   sacc_n = sacc_q + mres;
			M_SUB:   sacc_n = sacc_q - mres;
			default: sacc_n = mres;
		endcase
	end

	// saturating Horner add
	always_comb begin
		hsum = mres + c_q[k_q];
		hovf = (mres[63] == c_q[k_q][63]) && (hsum[63] != mres[63]);
		hsat = hovf ? (mres[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff) : hsum;
	end

	// sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			k_q         <= '0;
			cvalid_q    <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) c_q[i] <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						t_q   <= t_n;
						tau_q <= tau_n;
						if (t_n == 25'sd0) begin
							pos_q   <= sp_q;
							stat_q  <= ST_DEGEN;
							state_q <= S_OUT;
						end else if (cvalid_q) begin
							state_q <= S_DIV_ISSUE;
						end else begin
							pc_q    <= '0;
							state_q <= S_SOLVE_ISSUE;
						end
					end
				end
				S_SOLVE_ISSUE: state_q <= S_SOLVE_WAIT;
				S_SOLVE_WAIT: begin
					if (mrsp.done) begin
						sacc_q <= sacc_n;
						case (uop.dst)
							D_T2: t2_q <= sacc_n;
							D_V1: v1_q <= sacc_n;
							D_C0: c_q[0] <= sacc_n;
							D_C1: c_q[1] <= sacc_n;
							D_C2: c_q[2] <= sacc_n;
							D_C3: c_q[3] <= sacc_n;
							D_C4: c_q[4] <= sacc_n;
							D_C5: c_q[5] <= sacc_n;
							default: ;
						endcase
						if (pc_q == 5'(NUM_UOPS - 1)) begin
							cvalid_q <= 1'b1;
							state_q  <= S_DIV_ISSUE;
						end else begin
							pc_q    <= pc_q + 5'd1;
							state_q <= S_SOLVE_ISSUE;
						end
					end
				end
				S_DIV_ISSUE: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						u_q     <= (tau_q[24] != t_q[24]) ? -64'(quot) : 64'(quot);
						acc_q   <= c_q[5];
						k_q     <= 3'd4;
						ovf_q   <= 1'b0;
						state_q <= S_HORN_ISSUE;
					end
				end
				S_HORN_ISSUE: state_q <= S_HORN_WAIT;
				S_HORN_WAIT: begin
					if (mrsp.done) begin
						acc_q <= hsat;
						ovf_q <= ovf_q | mrsp.ovf | hovf;
						if (k_q == 3'd0) begin
							state_q <= S_FIN_ISSUE;
						end else begin
							k_q     <= k_q - 3'd1;
							state_q <= S_HORN_ISSUE;
						end
					end
				end
				S_FIN_ISSUE: state_q <= S_FIN_WAIT;
				S_FIN_WAIT: begin
					if (mrsp.done) begin
						// narrow to Q16.16 with clamping
						if (mres > 64'sh7fff_ffff) begin
							pos_q  <= 32'sh7fff_ffff;
							stat_q <= ST_SAT;
						end else if (mres < -64'sh8000_0000) begin
							pos_q  <= 32'sh8000_0000;
							stat_q <= ST_SAT;
						end else begin
							pos_q  <= mres[31:0];
							stat_q <= (ovf_q | mrsp.ovf) ? ST_SAT : ST_OK;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						position_q  <= pos_q;
						status_q    <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// any register write makes the coefficients stale
			if (cfg_we) cvalid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> (state_q == S_SOLVE_WAIT || state_q == S_HORN_WAIT ||
			state_q == S_FIN_WAIT))
		else $error("multiplier result outside a wait state");
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider result outside the divide state");
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");
`endif

endmodule

[rtl/qti_mul.sv]
// ----------------------------------------------------------------------------
// qti_mul: iterative signed multiply with rounding shift and saturation
// 64x64 product from four 32x32 partial products, then round to nearest
// (halves away from zero), shift and clamp to the signed 64-bit range.
// ----------------------------------------------------------------------------
module qti_mul import qti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mul_req_t           req,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output mul_rsp_t           rsp,
	output logic signed [63:0] res
);

	typedef enum logic [1:0] {U_IDLE, U_PP, U_RND, U_SAT} ustate_t;

	ustate_t      state_q;
	logic [1:0]   step_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	sh_sel_t      sh_q;
	logic [127:0] prod_q, rnd_q;
	logic         done_q, ovf_q;
	logic [63:0]  res_q;

	logic [63:0]  a_mag, b_mag;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh, rnd_n;
	logic [63:0]  lim, mag, res_n;
	logic         ovf_n;

	// take magnitudes
	assign a_mag = a[63] ? 64'(-a) : 64'(a);
	assign b_mag = b[63] ? 64'(-b) : 64'(b);

	// select the partial product for this step
	assign pa = step_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb = step_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp = pa * pb;

	always_comb begin
		case (step_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// round and shift
	always_comb begin
		case (sh_q)
			SH_16:   rnd_n = (prod_q + (128'd1 << 15)) >> 16;
			SH_32:   rnd_n = (prod_q + (128'd1 << 31)) >> 32;
			SH_33:   rnd_n = (prod_q + (128'd1 << 32)) >> 33;
			default: rnd_n = prod_q;
		endcase
	end

	// clamp and restore sign
	always_comb begin
		lim   = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		ovf_n = (|rnd_q[127:64]) || (rnd_q[63:0] > lim);
		mag   = ovf_n ? lim : rnd_q[63:0];
		res_n = neg_q ? 64'(-mag) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			step_q  <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						ma_q    <= a_mag;
						mb_q    <= b_mag;
						neg_q   <= a[63] ^ b[63];
						sh_q    <= req.sh;
						prod_q  <= '0;
						step_q  <= 2'd0;
						state_q <= U_PP;
					end
				end
				U_PP: begin
					prod_q <= prod_q + pp_sh;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) state_q <= U_RND;
				end
				U_RND: begin
					rnd_q   <= rnd_n;
					state_q <= U_SAT;
				end
				U_SAT: begin
					res_q   <= res_n;
					ovf_q   <= ovf_n;
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign res      = res_q;

endmodule

[rtl/qti_div.sv]
// ----------------------------------------------------------------------------
// qti_div: restoring divider for the normalised local time
// Returns round(num_mag * 2^32 / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qti_div import qti_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [TIME_W-1:0]   num_mag,
	input  logic [TIME_W-1:0]   den,
	output logic                done,
	output logic [DIV_BITS-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_BITS);

	logic                busy_q, done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_BITS-1:0] n_q;
	logic [TIME_W-1:0]   rem_q, den_q;

	logic [TIME_W:0]     trial;
	logic                fits;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, n_q[DIV_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				// dividend with half the divisor added for rounding
				n_q    <= {1'b0, num_mag, 32'd0} + DIV_BITS'(den >> 1);
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? TIME_W'(trial - {1'b0, den_q}) : trial[TIME_W-1:0];
				n_q   <= {n_q[DIV_BITS-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

[sim/quintic_trajectory_interpolator_test.sv]
// ----------------------------------------------------------------------------
// quintic_trajectory_interpolator_test: self-checking bench for the interpolator
// Loads several segment settings through the register port, sends sample
// times with random idling on both sides and checks every position and status
// against a cycle-free predictor of the coefficient solve and Horner chain.
// ----------------------------------------------------------------------------
module quintic_trajectory_interpolator_test;
	import qti_pkg::*;

	typedef struct {
		logic [31:0] pos;
		logic [1:0]  st;
	} sample_res_t;

	// Segment predictor and store of expected positions
	class position_scoreboard;
		longint sp, sv, sa, ep, ev, ea, t0, t1;
		longint b[6];
		bit     solved;
		sample_res_t pending[$];
		int     errors;
		int     checked;

		function void reset_regs();
			sp = 0; sv = 0; sa = 0; ep = 0; ev = 0; ea = 0;
			t0 = 0; t1 = 655360;
			solved = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				CFG_START_POS:  sp = longint'($signed(d));
				CFG_START_VEL:  sv = longint'($signed(d));
				CFG_START_ACC:  sa = longint'($signed(d));
				CFG_END_POS:    ep = longint'($signed(d));
				CFG_END_VEL:    ev = longint'($signed(d));
				CFG_END_ACC:    ea = longint'($signed(d));
				CFG_START_TIME: t0 = longint'(d[23:0]);
				CFG_END_TIME:   t1 = longint'(d[23:0]);
				default: ;
			endcase
			solved = 0;
		endfunction

		// round(a*b / 2^sh), halves away from zero, clamped to 64 bits
		function longint mul_rnd(longint a, longint b_, int sh, inout bit ovf);
			bit neg;
			logic [127:0] p;
			logic [127:0] lim;
			logic [63:0] ma, mb;
			neg = (a < 0) != (b_ < 0);
			ma = a < 0 ? -a : a;
			mb = b_ < 0 ? -b_ : b_;
			p = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (sh - 1))) >> sh;
			lim = neg ? (128'd1 << 63) : (128'd1 << 63) - 1;
			if (p > lim) begin
				ovf = 1;
				p = lim;
			end
			return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		endfunction

		function longint sat_sum(longint a, longint c, inout bit ovf);
			longint s;
			s = a + c;
			if (c > 0 && s < a) begin
				ovf = 1;
				return 64'sh7FFFFFFFFFFFFFFF;
			end
			if (c < 0 && s > a) begin
				ovf = 1;
				return 64'sh8000000000000000;
			end
			return s;
		endfunction

		function void solve_coeffs(longint t);
			bit d;
			longint t2, h, v0, v1;
			d = 0;
			t2 = t * t;
			h = (ep - sp) * 65536;
			v0 = sv * t;
			v1 = ev * t;
			b[0] = sp * 65536;
			b[1] = v0;
			b[2] = mul_rnd(sa, t2, 33, d);
			b[3] = 10 * h - 4 * v1 - 6 * v0 - mul_rnd(3 * sa - ea, t2, 33, d);
			b[4] = -15 * h + 7 * v1 + 8 * v0 + mul_rnd(3 * sa - 2 * ea, t2, 33, d);
			b[5] = 6 * h - 3 * (v0 + v1) + mul_rnd(ea - sa, t2, 33, d);
			solved = 1;
		endfunction

		// Note an accepted sample time and queue its position
		function void note_sample(logic [23:0] ts);
			sample_res_t r;
			longint t, tau, u, acc, p;
			logic [63:0] num, den, q;
			bit ovf;
			ovf = 0;
			t = t1 - t0;
			tau = longint'(ts) - t0;
			if (t == 0) begin
				r.pos = sp[31:0];
				r.st = ST_DEGEN;
				pending.push_back(r);
				return;
			end
			if (!solved) solve_coeffs(t);
			num = (tau < 0 ? -tau : tau) << 32;
			den = t < 0 ? -t : t;
			q = (num + den / 2) / den;
			u = ((tau < 0) != (t < 0)) ? -longint'(q) : longint'(q);
			acc = b[5];
			for (int k = 4; k >= 0; k--)
				acc = sat_sum(mul_rnd(acc, u, 32, ovf), b[k], ovf);
			p = mul_rnd(acc, 1, 16, ovf);
			if (p > 64'sd2147483647) begin
				p = 64'sd2147483647;
				ovf = 1;
			end else if (p < -64'sd2147483648) begin
				p = -64'sd2147483648;
				ovf = 1;
			end
			r.pos = p[31:0];
			r.st = ovf ? ST_SAT : ST_OK;
			pending.push_back(r);
		endfunction

		// Check a returned position against the oldest expectation
		function void check_result(logic [31:0] pos, logic [1:0] st);
			sample_res_t r;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result position=%h status=%0d", pos, st);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (pos !== r.pos) begin
				$error("position: expected %h, got %h", r.pos, pos);
				errors++;
			end
			if (st !== r.st) begin
				$error("status: expected %0d, got %0d", r.st, st);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [23:0] sample_time;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] position;
	logic [1:0]  status;

	position_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	int sent;

	quintic_trajectory_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_time(sample_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.position(position), .status(status)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver side: stall at random, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(position, status);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", sb.pending.size());
			$display("quintic_trajectory_interpolator_test: FAIL");
			$finish;
		end
	end

	// Write one register, then drop the write enable
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Hold the request until accepted, idling first at random
	task automatic send_sample(logic [23:0] ts);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1;
		sample_time <= ts;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_sample(ts);
		sent++;
		in_valid <= 0;
		@(posedge clk);
	endtask

	// Wait for all results, then let the block settle
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			default: return $signed($urandom_range(0, 32'h000FFFFF)) -
				$signed(32'h00080000);
		endcase
	endfunction

	// Mostly times near the segment, some anywhere
	function automatic logic [23:0] rnd_time();
		if ($urandom_range(9) < 2)
			return 24'($urandom);
		return 24'($urandom_range(0, 24'h0C0000));
	endfunction

	task automatic load_segment(bit extreme);
		logic [23:0] a, c;
		for (int i = 0; i < 6; i++)
			write_reg(3'(i), extreme ? rnd_val() : ($urandom_range(0, 32'h3FFFF) -
				32'h20000));
		a = 24'($urandom_range(0, 24'h040000));
		c = 24'(a + $urandom_range(1, 24'h080000));
		if ($urandom_range(9) == 0)
			c = a;
		else if ($urandom_range(9) == 0) begin
			c = a;
			a = 24'(a + $urandom_range(1, 24'h040000));
		end
		write_reg(CFG_START_TIME, 32'(a));
		write_reg(CFG_END_TIME, 32'(c));
	endtask

	initial begin
		logic [23:0] dir_times[8];
		sb = new();
		sb.reset_regs();
		arst_n = 0;
		cfg_we = 0; cfg_idx = CFG_START_POS; cfg_data = 0;
		in_valid = 0; sample_time = 0; out_ready = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		quiet_cycles = 0; sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset defaults: all-zero polynomial, extremes of the time field
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h0A0000);
		drain();

		// Typical move, boundaries, extrapolation and overflow
		write_reg(CFG_START_POS, 32'h00010000);
		write_reg(CFG_START_VEL, 32'h00008000);
		write_reg(CFG_START_ACC, 32'hFFFF0000);
		write_reg(CFG_END_POS, 32'h00640000);
		write_reg(CFG_END_VEL, 32'hFFFF8000);
		write_reg(CFG_END_ACC, 32'h00020000);
		write_reg(CFG_START_TIME, 32'h00010000);
		write_reg(CFG_END_TIME, 32'h00030000);
		dir_times = '{24'h010000, 24'h030000, 24'h020000, 24'h000000,
			24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h018000};
		foreach (dir_times[i]) send_sample(dir_times[i]);
		drain();

		// End before start, extreme boundary values
		write_reg(CFG_START_POS, 32'h80000000);
		write_reg(CFG_END_POS, 32'h7FFFFFFF);
		write_reg(CFG_START_VEL, 32'h7FFFFFFF);
		write_reg(CFG_END_ACC, 32'h80000000);
		write_reg(CFG_START_TIME, 32'h00FFFFFF);
		write_reg(CFG_END_TIME, 32'h00000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h000000);
		send_sample(24'h800000);
		drain();

		// Zero-length interval; index beyond the list cannot occur on 3 bits
		write_reg(CFG_END_TIME, 32'h00FFFFFF);
		send_sample(24'h123456);
		send_sample(24'h000000);
		drain();

		// Random phases over idling mixes and fresh segments
		for (int ph = 0; ph < 24; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
			endcase
			load_segment(ph % 3 == 2);
			repeat (78) send_sample(rnd_time());
			drain();
		end

		$display("sent %0d sample times over 28 segment settings, %0d results checked",
			sent, sb.checked);
		if (sb.errors == 0)
			$display("quintic_trajectory_interpolator_test: PASS");
		else
			$display("quintic_trajectory_interpolator_test: FAIL");
		$finish;
	end

endmodule
